FILE: src/spi_pkg.sv
// Shared definitions for the segment versus polyline crossing block.
// Holds default sizes, the output index width and the divider handshake structs.
// No dependencies.
package spi_pkg;

    localparam int COORD_BITS_DEF   = 32;
    localparam int MAX_VERTICES_DEF = 4096;
    localparam int EDGE_W           = 12;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: src/segment_polyline_intersect.sv
// Segment versus polyline crossing test, one polyline vertex per input request.
// The s_ channel carries the query segment, one vertex and the first/last flags.
// Each vertex after the first closes an edge with the stored previous vertex.
// A request on the last vertex produces one m_ request: hit flag, index of the
// first crossing edge and its crossing point, truncated toward zero.
// A first vertex or an untested edge goes from ST_PREP straight to ST_DONE. A
// tested edge runs ST_MUL, ST_NORM and ST_TEST, all six cross products going
// through one shared multiplier. The first crossing edge adds two point passes,
// x then y, each through ST_PA to ST_FIN and the one bit per cycle divider.
// s_ready is high only while the sequencer is idle; one request is in work.
// A finished result waits in the output register; a stalled receiver holds the
// sequencer only when the next result is ready before the previous one left.
// Reset clears the previous vertex, edge count and found state to zero and
// drops m_valid.
// Depends on spi_pkg and spi_div.
module segment_polyline_intersect import spi_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_seg_start_x,
    input  logic signed [COORD_BITS-1:0] s_seg_start_y,
    input  logic signed [COORD_BITS-1:0] s_seg_end_x,
    input  logic signed [COORD_BITS-1:0] s_seg_end_y,
    input  logic signed [COORD_BITS-1:0] s_vertex_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_y,
    input  logic                         s_first_vertex,
    input  logic                         s_last_vertex,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [EDGE_W-1:0]            m_edge_index,
    output logic signed [COORD_BITS-1:0] m_hit_x,
    output logic signed [COORD_BITS-1:0] m_hit_y
);

    localparam int W   = COORD_BITS;
    localparam int MW  = W + 2;
    localparam int PW  = 2 * W + 4;
    localparam int NW  = 3 * W + 5;
    localparam int QW  = W + 1;
    localparam int ECW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_NORM = 4'd3;
    localparam logic [3:0] ST_TEST = 4'd4;
    localparam logic [3:0] ST_PA   = 4'd5;
    localparam logic [3:0] ST_PB   = 4'd6;
    localparam logic [3:0] ST_PC   = 4'd7;
    localparam logic [3:0] ST_PD   = 4'd8;
    localparam logic [3:0] ST_DIVW = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       csel_reg, csel_next;

    // Latched request.
    logic signed [W-1:0] x0_reg, y0_reg, x1_reg, y1_reg, vx_reg, vy_reg;
    logic                first_reg, last_reg;

    // Persistent polyline state.
    logic signed [W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [ECW-1:0]      edge_count_reg, edge_count_next;
    logic                found_reg, found_next;
    logic [ECW-1:0]      found_edge_reg, found_edge_next;
    logic signed [W-1:0] found_x_reg, found_x_next, found_y_reg, found_y_next;

    // Edge arithmetic.
    logic signed [W:0]    dx_reg, dy_reg, ex_reg, ey_reg, fx_reg, fy_reg;
    logic signed [W:0]    dx_next, dy_next, ex_next, ey_next, fx_next, fy_next;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_reg, prod_next, acc_reg, acc_next;
    logic signed [PW-1:0] den_reg, den_next, n1_reg, n1_next, n2_reg, n2_next;
    logic signed [NW-1:0] num_reg, num_next;
    logic                 neg_reg, neg_next;
    logic signed [W:0]    dsel;
    logic signed [W-1:0]  csel_origin;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_hit_next;
    logic [EDGE_W-1:0]   m_edge_reg, m_edge_next;
    logic signed [W-1:0] m_x_reg, m_x_next, m_y_reg, m_y_next;

    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;
    logic [NW-1:0]       div_num;
    logic [QW-1:0]       div_quo;
    logic                div_rem_nz;

    logic                 edge_hit;
    logic signed [W+1:0]  q_s, floor_q;
    logic signed [W+2:0]  pt_sum, pt_res;
    logic [EDGE_W+ECW-1:0] edge_wide;

    spi_div #(.COORD_BITS(COORD_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .num     (div_num),
        .den     (den_reg),
        .stat    (div_stat),
        .quo     (div_quo),
        .rem_nz  (div_rem_nz)
    );

    assign dsel        = csel_reg ? dy_reg : dx_reg;
    assign csel_origin = csel_reg ? y0_reg : x0_reg;
    // The divider loads in ST_PD, the same cycle the sign is captured, so it
    // takes the magnitude straight from the numerator's sign bit.
    assign div_num     = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign div_ctrl.start = (state_reg == ST_PD);

    // Operand selection for the one shared multiplier.
    always_comb begin
        mul_a = MW'(dsel);
        mul_b = MW'(signed'({1'b0, n1_reg[W:0]}));
        if (state_reg == ST_MUL) begin
            case (cnt_reg)
                3'd0: begin mul_a = MW'(ey_reg); mul_b = MW'(dx_reg); end
                3'd1: begin mul_a = MW'(dy_reg); mul_b = MW'(ex_reg); end
                3'd2: begin mul_a = MW'(dy_reg); mul_b = MW'(fx_reg); end
                3'd3: begin mul_a = MW'(fy_reg); mul_b = MW'(dx_reg); end
                3'd4: begin mul_a = MW'(ey_reg); mul_b = MW'(fx_reg); end
                3'd5: begin mul_a = MW'(ex_reg); mul_b = MW'(fy_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == ST_PB) begin
            mul_b = MW'(signed'({1'b0, n1_reg[2*W+1:W+1]}));
        end
    end

    assign edge_hit = (den_reg != '0) && (n2_reg > 0) && ((den_reg - n2_reg) > 0)
                    && (n1_reg > 0) && ((den_reg - n1_reg) > 0);

    // Floor of the offset, then step to truncation toward zero of the point.
    assign q_s     = signed'({1'b0, div_quo});
    assign floor_q = neg_reg ? (-q_s - (W+2)'(div_rem_nz)) : q_s;
    assign pt_sum  = (W+3)'(csel_origin) + (W+3)'(floor_q);
    assign pt_res  = (pt_sum < 0 && div_rem_nz) ? pt_sum + (W+3)'(1) : pt_sum;

    assign edge_wide = {{EDGE_W{1'b0}}, found_edge_reg};

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        csel_next       = csel_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        edge_count_next = edge_count_reg;
        found_next      = found_reg;
        found_edge_next = found_edge_reg;
        found_x_next    = found_x_reg;
        found_y_next    = found_y_reg;
        dx_next = dx_reg; dy_next = dy_reg; ex_next = ex_reg;
        ey_next = ey_reg; fx_next = fx_reg; fy_next = fy_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        den_next  = den_reg;
        n1_next   = n1_reg;
        n2_next   = n2_reg;
        num_next  = num_reg;
        neg_next  = neg_reg;
        m_valid_next = m_valid_reg;
        m_hit_next   = m_hit_reg;
        m_edge_next  = m_edge_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (first_reg) begin
                    edge_count_next = '0;
                    found_next      = 1'b0;
                    found_edge_next = '0;
                    found_x_next    = '0;
                    found_y_next    = '0;
                    state_next      = ST_DONE;
                end else if (edge_count_reg < ECW'(MAX_VERTICES - 1)) begin
                    dx_next    = (W+1)'(x1_reg) - (W+1)'(x0_reg);
                    dy_next    = (W+1)'(y1_reg) - (W+1)'(y0_reg);
                    ex_next    = (W+1)'(vx_reg) - (W+1)'(prev_x_reg);
                    ey_next    = (W+1)'(vy_reg) - (W+1)'(prev_y_reg);
                    fx_next    = (W+1)'(prev_x_reg) - (W+1)'(x0_reg);
                    fy_next    = (W+1)'(prev_y_reg) - (W+1)'(y0_reg);
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                // The product of the previous step is folded in while the next one forms.
                prod_next = mul_a * mul_b;
                case (cnt_reg)
                    3'd1, 3'd3, 3'd5: acc_next = prod_reg;
                    3'd2: den_next = acc_reg - prod_reg;
                    3'd4: n2_next  = acc_reg - prod_reg;
                    3'd6: n1_next  = acc_reg - prod_reg;
                    default: acc_next = acc_reg;
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd6) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (den_reg < 0) begin
                    den_next = -den_reg;
                    n1_next  = -n1_reg;
                    n2_next  = -n2_reg;
                end
                state_next = ST_TEST;
            end
            ST_TEST: begin
                edge_count_next = edge_count_reg + ECW'(1);
                if (edge_hit && !found_reg) begin
                    found_edge_next = edge_count_reg;
                    csel_next       = 1'b0;
                    state_next      = ST_PA;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PA: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_PB;
            end
            ST_PB: begin
                acc_next   = prod_reg;
                prod_next  = mul_a * mul_b;
                state_next = ST_PC;
            end
            ST_PC: begin
                num_next   = NW'(acc_reg) + (NW'(prod_reg) <<< (W + 1));
                state_next = ST_PD;
            end
            ST_PD: begin
                neg_next   = num_reg[NW-1];
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!csel_reg) begin
                    found_x_next = pt_res[W-1:0];
                    csel_next    = 1'b1;
                    state_next   = ST_PA;
                end else begin
                    found_y_next = pt_res[W-1:0];
                    found_next   = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                prev_x_next = vx_reg;
                prev_y_next = vy_reg;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_hit_next      = found_reg;
                    m_edge_next     = found_reg ? edge_wide[EDGE_W-1:0] : '0;
                    m_x_next        = found_reg ? found_x_reg : '0;
                    m_y_next        = found_reg ? found_y_reg : '0;
                    edge_count_next = '0;
                    found_next      = 1'b0;
                    found_edge_next = '0;
                    found_x_next    = '0;
                    found_y_next    = '0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            csel_reg       <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            edge_count_reg <= '0;
            found_reg      <= 1'b0;
            found_edge_reg <= '0;
            found_x_reg    <= '0;
            found_y_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            csel_reg       <= csel_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            edge_count_reg <= edge_count_next;
            found_reg      <= found_next;
            found_edge_reg <= found_edge_next;
            found_x_reg    <= found_x_next;
            found_y_reg    <= found_y_next;
            m_valid_reg    <= m_valid_next;
        end
        if (state_reg == ST_IDLE && s_valid) begin
            x0_reg    <= s_seg_start_x;
            y0_reg    <= s_seg_start_y;
            x1_reg    <= s_seg_end_x;
            y1_reg    <= s_seg_end_y;
            vx_reg    <= s_vertex_x;
            vy_reg    <= s_vertex_y;
            first_reg <= s_first_vertex;
            last_reg  <= s_last_vertex;
        end
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        den_reg  <= den_next;
        n1_reg   <= n1_next;
        n2_reg   <= n2_next;
        num_reg  <= num_next;
        neg_reg  <= neg_next;
        m_hit_reg  <= m_hit_next;
        m_edge_reg <= m_edge_next;
        m_x_reg    <= m_x_next;
        m_y_reg    <= m_y_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_edge_index = m_edge_reg;
    assign m_hit_x      = m_x_reg;
    assign m_hit_y      = m_y_reg;

endmodule

FILE: src/spi_div.sv
// Iterative restoring divider for the crossing point: one quotient bit per cycle.
// Takes an unsigned magnitude and a positive divisor known to bound the quotient.
// Depends on spi_pkg.
module spi_div import spi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  div_ctrl_t                  ctrl,
    input  logic [3*COORD_BITS+4:0]    num,
    input  logic [2*COORD_BITS+3:0]    den,
    output div_stat_t                  stat,
    output logic [COORD_BITS:0]        quo,
    output logic                       rem_nz
);

    localparam int NW = 3 * COORD_BITS + 5;
    localparam int PW = 2 * COORD_BITS + 4;
    localparam int QW = COORD_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic [PW-1:0] rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [PW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [PW:0]   shifted;
    logic [PW+1:0] trial;

    // The quotient bits shift in at the bottom as the dividend bits leave at the top.
    always_comb begin
        shifted   = {rem_reg, q_reg[QW-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next  = num[NW-1:QW];
            q_next    = num[QW-1:0];
            den_next  = den;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[PW+1]) begin
                rem_next = trial[PW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = shifted[PW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = q_reg;
    assign rem_nz    = (rem_reg != '0);

endmodule

FILE: src/spi_checker.sv
// Port level checks for the crossing block, attached to the top level by bind.
// Depends on spi_pkg and segment_polyline_intersect.
module spi_checker import spi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_hit,
    input logic [EDGE_W-1:0]     m_edge_index,
    input logic [COORD_BITS-1:0] m_hit_x,
    input logic [COORD_BITS-1:0] m_hit_y
);

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // One request is worked at a time, so ready drops right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // A miss reports zero index and point.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_edge_index == '0 && m_hit_x == '0 && m_hit_y == '0)
        else $error("miss with nonzero fields");

    // A stalled result keeps its fields.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_edge_index)
        && $stable(m_hit_x) && $stable(m_hit_y))
        else $error("stalled result changed");

endmodule

bind segment_polyline_intersect spi_checker #(.COORD_BITS(COORD_BITS)) u_spi_checker (.*);

FILE: tb/tb_segment_polyline_intersect.sv
// Self-checking testbench for segment_polyline_intersect: directed table, an over-limit
// polyline, then random polylines. Predicts crossing results with exact wide arithmetic
// and compares every m_ request. Depends on spi_pkg and the segment_polyline_intersect RTL.
`timescale 1ns / 100ps

module tb_segment_polyline_intersect;
    import spi_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    // A short edge limit keeps the over-limit polyline to a few dozen requests.
    localparam int TB_MAX_V = 64;
    localparam int NRAND = 1360;
    localparam longint CYCLE_LIMIT = 1200000;

    typedef struct {
        logic signed [CB-1:0] sx0, sy0, sx1, sy1, vx, vy;
        logic first, last;
    } vertex_req_t;

    typedef struct {
        logic hit;
        logic [EDGE_W-1:0] idx;
        logic signed [CB-1:0] px, py;
    } crossing_t;

    typedef struct {
        vertex_req_t req;
        logic        has_exp;
        crossing_t   exp;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CB-1:0] s_seg_start_x = '0, s_seg_start_y = '0;
    logic signed [CB-1:0] s_seg_end_x = '0, s_seg_end_y = '0;
    logic signed [CB-1:0] s_vertex_x = '0, s_vertex_y = '0;
    logic s_first_vertex = 1'b0, s_last_vertex = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [EDGE_W-1:0] m_edge_index;
    logic signed [CB-1:0] m_hit_x, m_hit_y;

    segment_polyline_intersect #(.MAX_VERTICES(TB_MAX_V)) u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic signed [CB-1:0] last_vx, last_vy;
    int unsigned edges_seen;
    crossing_t first_cross;

    crossing_t pending_q[$];
    int errors = 0;
    longint cycles = 0;
    logic stim_done = 1'b0;

    function automatic logic edge_crossing(vertex_req_t r, output logic signed [CB-1:0] px,
                                           output logic signed [CB-1:0] py);
        logic signed [255:0] dx, dy, ex, ey, fx, fy, den, n1, n2, qx, qy;
        dx = 256'(r.sx1) - 256'(r.sx0);
        dy = 256'(r.sy1) - 256'(r.sy0);
        px = '0;
        py = '0;
        if (dx == 0 && dy == 0) return 1'b0;
        ex = 256'(r.vx) - 256'(last_vx);
        ey = 256'(r.vy) - 256'(last_vy);
        fx = 256'(last_vx) - 256'(r.sx0);
        fy = 256'(last_vy) - 256'(r.sy0);
        den = ey * dx - dy * ex;
        if (den == 0) return 1'b0;
        n2 = dy * fx - fy * dx;
        n1 = ey * fx - ex * fy;
        if (den < 0) begin
            den = -den;
            n1 = -n1;
            n2 = -n2;
        end
        if (!(n2 > 0 && den - n2 > 0 && n1 > 0 && den - n1 > 0)) return 1'b0;
        // Signed division in SystemVerilog truncates toward zero.
        qx = (256'(r.sx0) * den + dx * n1) / den;
        qy = (256'(r.sy0) * den + dy * n1) / den;
        px = qx[CB-1:0];
        py = qy[CB-1:0];
        return 1'b1;
    endfunction

    function automatic void predict_vertex(vertex_req_t r, output logic produces,
                                           output crossing_t res);
        logic signed [CB-1:0] hx, hy;
        if (r.first) begin
            edges_seen = 0;
            first_cross = '{1'b0, '0, '0, '0};
        end else if (edges_seen < TB_MAX_V - 1) begin
            if (edge_crossing(r, hx, hy) && !first_cross.hit)
                first_cross = '{1'b1, edges_seen[EDGE_W-1:0], hx, hy};
            edges_seen++;
        end
        last_vx = r.vx;
        last_vy = r.vy;
        produces = r.last;
        res = first_cross;
        if (r.last) begin
            edges_seen = 0;
            first_cross = '{1'b0, '0, '0, '0};
        end
    endfunction

    task automatic send_vertex(vertex_req_t r, logic has_exp, crossing_t exp_r);
        logic produces;
        crossing_t res;
        s_valid <= 1'b1;
        s_seg_start_x <= r.sx0;
        s_seg_start_y <= r.sy0;
        s_seg_end_x <= r.sx1;
        s_seg_end_y <= r.sy1;
        s_vertex_x <= r.vx;
        s_vertex_y <= r.vy;
        s_first_vertex <= r.first;
        s_last_vertex <= r.last;
        do @(posedge aclk); while (!s_ready);
        predict_vertex(r, produces, res);
        if (produces) pending_q.push_back(has_exp ? exp_r : res);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return $signed($urandom);
            1: return $signed(32'($urandom_range(0, 200)) - 32'sd100);
            2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 2000000)) - 32'sd1000000);
        endcase
    endfunction

    // Receiver: stalls on a repeating pattern with occasional random extra stalls.
    int unsigned stall_phase = 0;
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        m_ready <= ((stall_phase % 11) < 7) && ($urandom_range(0, 40) != 0);
    end

    always @(posedge aclk) begin
        crossing_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result hit=%0b idx=%0d", m_hit, m_edge_index);
            end else begin
                e = pending_q.pop_front();
                if (m_hit !== e.hit || m_edge_index !== e.idx || m_hit_x !== e.px ||
                    m_hit_y !== e.py) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
                                 e.hit, e.idx, e.px, e.py, m_hit, m_edge_index, m_hit_x, m_hit_y);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_segment_polyline_intersect NOT OK");
            $finish;
        end
    end

    dir_row_t dir_tbl[$];
    crossing_t none_r = '{1'b0, '0, '0, '0};

    function automatic vertex_req_t mk(int sx0, int sy0, int sx1, int sy1, int vx, int vy,
                                       logic f, logic l);
        vertex_req_t r;
        r = '{sx0, sy0, sx1, sy1, vx, vy, f, l};
        return r;
    endfunction

    initial begin
        vertex_req_t r;
        int len, mode, k;
        last_vx = '0;
        last_vy = '0;
        edges_seen = 0;
        first_cross = '{1'b0, '0, '0, '0};

        // Right after reset: no first flag, edge from the origin.
        dir_tbl.push_back('{mk(-10, 5, 10, 5, 0, 10, 1'b0, 1'b1), 1'b1, '{1'b1, '0, 0, 5}});
        // Single vertex polyline reports no hit.
        dir_tbl.push_back('{mk(-10, 5, 10, 5, 3, 3, 1'b1, 1'b1), 1'b1, none_r});
        // Degenerate query segment never hits.
        dir_tbl.push_back('{mk(4, 4, 4, 4, 0, 0, 1'b1, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(4, 4, 4, 4, 8, 8, 1'b0, 1'b1), 1'b1, none_r});
        // A parallel edge never hits, nor an edge that meets the line past the segment end.
        dir_tbl.push_back('{mk(0, 0, 10, 0, 0, 1, 1'b1, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(0, 0, 10, 0, 10, 1, 1'b0, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(0, 0, 10, 0, 20, 0, 1'b0, 1'b1), 1'b1, none_r});
        // Endpoint touch is not strictly inside.
        dir_tbl.push_back('{mk(0, 0, 10, 0, 5, 0, 1'b1, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(0, 0, 10, 0, 5, 9, 1'b0, 1'b1), 1'b1, none_r});
        // Two crossings: first one is reported, negative rounding toward zero.
        dir_tbl.push_back('{mk(0, 0, -7, -3, -1, 1, 1'b1, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(0, 0, -7, -3, -5, -6, 1'b0, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(0, 0, -7, -3, -4, 3, 1'b0, 1'b1), 1'b0, none_r});
        // Coordinate extremes.
        dir_tbl.push_back('{mk(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                               32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                               32'sh7fffffff, 32'sh80000000, 1'b0, 1'b1), 1'b0, none_r});
        dir_tbl.push_back('{mk(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                               32'sh80000000, 32'sh80000000, 1'b1, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                               32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b1), 1'b0, none_r});
        // Polyline left open, then a new first vertex abandons it.
        dir_tbl.push_back('{mk(-10, 5, 10, 5, 0, 0, 1'b1, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(-10, 5, 10, 5, 0, 10, 1'b0, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(-10, 5, 10, 5, 50, 50, 1'b1, 1'b0), 1'b0, none_r});
        dir_tbl.push_back('{mk(-10, 5, 10, 5, 60, 60, 1'b0, 1'b1), 1'b1, none_r});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[i]) begin
            send_vertex(dir_tbl[i].req, dir_tbl[i].has_exp, dir_tbl[i].exp);
            idle_gap();
        end

        // Pause until every outstanding result has come back.
        s_valid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (100) @(posedge aclk);

        // One polyline beyond the edge limit, cheap coordinates so most edges miss.
        r = mk(0, 0, 1, 1, 0, 0, 1'b1, 1'b0);
        send_vertex(r, 1'b0, none_r);
        for (k = 1; k <= TB_MAX_V + 2; k++) begin
            r = mk(0, 0, 0, 1, k, (k % 2) ? 3 : -3, 1'b0, k == TB_MAX_V + 2);
            if (k == TB_MAX_V - 1) r = mk(0, 0, 0, 1, -5, 0, 1'b0, 1'b0);
            send_vertex(r, 1'b0, none_r);
        end

        k = 0;
        while (k < NRAND) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
            mode = $urandom_range(0, 3);
            r.sx0 = rand_coord(mode);
            r.sy0 = rand_coord(mode);
            r.sx1 = ($urandom_range(0, 30) == 0) ? r.sx0 : rand_coord(mode);
            r.sy1 = ($urandom_range(0, 30) == 0) ? r.sy0 : rand_coord(mode);
            for (int v = 0; v < len && k < NRAND; v++) begin
                r.vx = rand_coord(mode);
                r.vy = rand_coord(mode);
                r.first = (v == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 60) == 0);
                r.last = (v == len - 1) ? ($urandom_range(0, 15) != 0) :
                         ($urandom_range(0, 60) == 0);
                send_vertex(r, 1'b0, none_r);
                k++;
                idle_gap();
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        wait (pending_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("tb_segment_polyline_intersect OK");
        end else begin
            $display("tb_segment_polyline_intersect NOT OK");
        end
        $finish;
    end

endmodule
